/* rtl/core/rfp_pkg.sv */
// shared types and constants for the range finder frame parser
package rfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIST_W    = 32;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_SYNC1  = 3'd0;
    localparam logic [POS_W-1:0] POS_SYNC2  = 3'd1;
    localparam logic [POS_W-1:0] POS_STATUS = 3'd2;
    localparam logic [POS_W-1:0] POS_DIST0  = 3'd3;
    localparam logic [POS_W-1:0] POS_CHECK  = 3'd7;

    localparam logic [BYTE_W-1:0] STATUS_GOOD = 8'h00;

    // what the parser makes of the byte it is looking at
    typedef struct packed {
        logic              emit;
        logic              frame_ok;
        logic [DIST_W-1:0] distance_mm;
    } t_rfp_result;

endpackage

/* rtl/core/range_frame_parser_unit.sv */
// top level of the range finder frame parser
//
// takes one received byte per beat, hunts for the two-byte sync header set
// by the sync_first / sync_second registers, then gathers status, a 32-bit
// big-endian distance in mm and an 8-bit sum checksum; the eighth byte of a
// frame gives one result beat (frame_ok, distance_mm), all other bytes give
// none. a byte can be accepted every cycle: the incoming byte is held in an
// input register, the parser state updates from it, and the result lands
// in an output register. throughput is one byte per cycle except when the
// output register stalls the input side: it only blocks the input side
// when it holds an untaken result and the byte waiting is a checksum byte.
// config writes take effect on the next byte processed.
module range_frame_parser_unit
    import rfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_frame_ok,
    output logic [DIST_W-1:0]    o_distance_mm,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata
);

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // output register
    logic              r_out_valid;
    logic              r_out_frame_ok;
    logic [DIST_W-1:0] r_out_distance;

    t_rfp_result res;
    logic        out_free;
    logic        step;

    // config registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // output slot is free if empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // held byte is consumed unless it makes a result with nowhere to go
    assign step       = r_in_valid && (!res.emit || out_free);
    assign o_in_ready = !r_in_valid || step;

    rfp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_frame_ok <= res.frame_ok;
            r_out_distance <= res.distance_mm;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_ok    = r_out_frame_ok;
    assign o_distance_mm = r_out_distance;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.emit) |=> r_out_valid)
        else $error("completed frame did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(step && res.emit))
        else $error("result overwritten before it was taken");

    a_bad_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_frame_ok) |-> (r_out_distance == '0))
        else $error("bad frame carries a distance");
`endif

endmodule

/* rtl/core/rfp_parser.sv */
// frame state and per-byte update of the range finder parser
module rfp_parser
    import rfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_sync_first,
    input  logic [BYTE_W-1:0] i_sync_second,
    output t_rfp_result       o_res
);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic              r_armed, n_armed;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic              r_zero,  n_zero;
    logic [DIST_W-1:0] r_dist,  n_dist;
    logic              ok;

    always_comb begin
        n_pos   = r_pos;
        n_armed = r_armed;
        n_sum   = r_sum;
        n_zero  = r_zero;
        n_dist  = r_dist;
        if (!r_armed) begin
            if (r_pos == POS_SYNC1 && i_byte == i_sync_first) begin
                n_pos = POS_SYNC2;
            end else if (r_pos == POS_SYNC2 && i_byte == i_sync_second) begin
                n_pos   = POS_STATUS;
                n_armed = 1'b1;
            end else begin
                n_pos = POS_SYNC1;
            end
        end else if (r_pos <= POS_STATUS) begin
            n_sum  = i_byte;
            n_zero = (i_byte == STATUS_GOOD);
            n_dist = '0;
            n_pos  = POS_DIST0;
        end else if (r_pos < POS_CHECK) begin
            n_sum  = r_sum + i_byte;
            n_dist = {r_dist[DIST_W-BYTE_W-1:0], i_byte};
            n_pos  = r_pos + 3'd1;
        end else begin
            n_pos   = POS_SYNC1;
            n_armed = 1'b0;
        end
    end

    assign ok                = r_zero && (r_sum == i_byte);
    assign o_res.emit        = r_armed && (r_pos == POS_CHECK);
    assign o_res.frame_ok    = ok;
    assign o_res.distance_mm = ok ? r_dist : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_SYNC1;
            r_armed <= 1'b0;
            r_sum   <= '0;
            r_zero  <= 1'b0;
            r_dist  <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_armed <= n_armed;
            r_sum   <= n_sum;
            r_zero  <= n_zero;
            r_dist  <= n_dist;
        end
    end

`ifndef SYNTHESIS
    a_hunt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_pos == POS_SYNC1 || r_pos == POS_SYNC2))
        else $error("hunt position out of range");

    a_armed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_pos >= POS_STATUS)
        else $error("armed before header complete");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.emit) |=> (!r_armed && r_pos == POS_SYNC1))
        else $error("parser did not return to hunting after a frame");
`endif

endmodule
